### hdl/nbc_pkg.sv
// Shared types and character constants for the NMEA burst collector.
`default_nettype none

package nbc_pkg;

  // Field widths of the request and result payloads.
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 9;

  // Characters that the sentence tracker looks for.
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_R      = 8'h52;
  localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
  localparam logic [BYTE_W-1:0] CH_C      = 8'h43;
  localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
  localparam logic [BYTE_W-1:0] CH_A      = 8'h41;
  localparam logic [BYTE_W-1:0] CH_V      = 8'h56;
  localparam logic [BYTE_W-1:0] CH_T      = 8'h54;

  // Distance from the '$' to the last letter of the sentence type.
  localparam logic [LEN_W-1:0] TYPE_OFFSET = 9'd5;

  // One result per received byte.
  typedef struct packed {
    logic [BYTE_W-1:0] store_index;
    logic [BYTE_W-1:0] store_byte;
    logic              block_done;
    logic [LEN_W-1:0]  block_length;
    logic              overflow;
    logic              seen_rmc;
    logic              seen_gga;
    logic              seen_vtg;
  } result_t;

endpackage

`default_nettype wire

### hdl/nmea_burst_collector.sv
// Top level of the NMEA burst collector: input stage, tracker and result stage.
// Each byte passes the input register, the combinational tracker and then the result register.
// Throughput: one byte per cycle while the downstream side accepts results, set by the
// combinational tracker logic between the input register and the result register.
// Reset: rst_n is synchronous and active low; it empties both stages and
// clears the byte count, sentence start, byte history and type flags.
`default_nettype none

module nmea_burst_collector #(
  parameter int BUFFER_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [7:0] store_index, [15:8] store_byte,
                                       // [24:16] block_length, [31:25] zero
  output logic             out_tlast,  // block_done
  output logic [3:0]       out_tuser   // [0] overflow, [1] seen_rmc,
                                       // [2] seen_gga, [3] seen_vtg
);

  logic                       hold_valid;
  logic [nbc_pkg::BYTE_W-1:0] hold_byte;
  logic                       out_free;
  logic                       step;
  nbc_pkg::result_t           res;
  nbc_pkg::result_t           out_res;

  // A held byte moves on when the result register has room.
  assign step = hold_valid && out_free;

  nbc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .take       (step),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  nbc_tracker #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (hold_byte),
    .res     (res)
  );

  nbc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  // Pack the result fields onto the stream ports.
  assign out_tdata = {7'd0, out_res.block_length, out_res.store_byte, out_res.store_index};
  assign out_tlast = out_res.block_done;
  assign out_tuser = {out_res.seen_vtg, out_res.seen_gga, out_res.seen_rmc, out_res.overflow};

endmodule

`default_nettype wire

### hdl/nbc_in_stage.sv
// Input register stage: holds one received byte until the tracker takes it.
`default_nettype none

module nbc_in_stage (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [nbc_pkg::BYTE_W-1:0] in_tdata,
  input  wire logic                      take,
  output logic                           hold_valid,
  output logic [nbc_pkg::BYTE_W-1:0]     hold_byte
);

  logic                       valid_r;
  logic [nbc_pkg::BYTE_W-1:0] byte_r;

  // The stage can accept whenever it is empty or is being drained this cycle.
  assign in_tready  = !valid_r || take;
  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

  // Valid flag of the stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

endmodule

`default_nettype wire

### hdl/nbc_tracker.sv
// Sentence tracker: byte counter, sentence type compare and block completion.
`default_nettype none

module nbc_tracker #(
  parameter int BUFFER_DEPTH = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step,
  input  wire logic [nbc_pkg::BYTE_W-1:0] rx_byte,
  output nbc_pkg::result_t                res
);

  localparam int CW = $clog2(BUFFER_DEPTH);

  logic [CW-1:0]              count_r, count_nxt;
  logic [CW-1:0]              start_r, start_nxt;
  logic [nbc_pkg::BYTE_W-1:0] prev1_r, prev1_nxt;
  logic [nbc_pkg::BYTE_W-1:0] prev2_r, prev2_nxt;
  logic                       rmc_r, rmc_nxt;
  logic                       gga_r, gga_nxt;
  logic                       vtg_r, vtg_nxt;

  logic [CW-1:0]               start_cur;
  logic [nbc_pkg::LEN_W-1:0]   count_ext;
  logic [nbc_pkg::LEN_W-1:0]   count_inc;
  logic                        type_pos;
  logic                        done;
  logic                        ovf;

  // Combinational evaluation of the byte held in the input stage.
  always_comb begin
    count_ext = nbc_pkg::LEN_W'(count_r);
    count_inc = count_ext + 9'd1;

    // A '$' moves the sentence start to this byte's position.
    start_cur = (rx_byte == nbc_pkg::CH_DOLLAR) ? count_r : start_r;

    // The type letters end five bytes after the sentence start.
    type_pos = (count_ext > 9'd2) &&
               (count_ext == nbc_pkg::LEN_W'(start_cur) + nbc_pkg::TYPE_OFFSET);

    rmc_nxt = rmc_r || (type_pos && prev2_r == nbc_pkg::CH_R &&
                        prev1_r == nbc_pkg::CH_M && rx_byte == nbc_pkg::CH_C);
    gga_nxt = gga_r || (type_pos && prev2_r == nbc_pkg::CH_G &&
                        prev1_r == nbc_pkg::CH_G && rx_byte == nbc_pkg::CH_A);
    vtg_nxt = vtg_r || (type_pos && prev2_r == nbc_pkg::CH_V &&
                        prev1_r == nbc_pkg::CH_T && rx_byte == nbc_pkg::CH_G);

    // A CR LF pair ends the block once all three types were seen.
    done = rmc_nxt && gga_nxt && vtg_nxt &&
           prev1_r == nbc_pkg::CH_CR && rx_byte == nbc_pkg::CH_LF;
    ovf  = !done && (count_inc >= nbc_pkg::LEN_W'(BUFFER_DEPTH));

    res.store_index  = nbc_pkg::BYTE_W'(count_r);
    res.store_byte   = rx_byte;
    res.block_done   = done;
    res.block_length = done ? count_inc : '0;
    res.overflow     = ovf;
    res.seen_rmc     = rmc_nxt;
    res.seen_gga     = gga_nxt;
    res.seen_vtg     = vtg_nxt;

    // Completion or a full buffer restarts collection; otherwise count up and shift history.
    count_nxt = CW'(count_inc);
    start_nxt = start_cur;
    prev2_nxt = prev1_r;
    prev1_nxt = rx_byte;
    if (done || ovf) begin
      count_nxt = '0;
      start_nxt = '0;
      prev2_nxt = '0;
      prev1_nxt = '0;
    end
  end

  // Collection state advances once per byte handed to the result stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      start_r <= '0;
      prev1_r <= '0;
      prev2_r <= '0;
      rmc_r   <= 1'b0;
      gga_r   <= 1'b0;
      vtg_r   <= 1'b0;
    end else if (step) begin
      count_r <= count_nxt;
      start_r <= start_nxt;
      prev1_r <= prev1_nxt;
      prev2_r <= prev2_nxt;
      rmc_r   <= rmc_nxt && !(done || ovf);
      gga_r   <= gga_nxt && !(done || ovf);
      vtg_r   <= vtg_nxt && !(done || ovf);
    end
  end

  // The count always stays below the buffer depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    nbc_pkg::LEN_W'(count_r) < nbc_pkg::LEN_W'(BUFFER_DEPTH))
    else $error("byte count reached the buffer depth");

  // Completion and overflow never come with the same byte.
  a_done_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    !(done && ovf))
    else $error("completion and overflow on one byte");

  // A completed block holds all three sentence types.
  a_done_flags: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (rmc_nxt && gga_nxt && vtg_nxt))
    else $error("block completed without all sentence types");

  // After completion or overflow, collection restarts from an empty state.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (done || ovf)) |=> (count_r == '0 && !rmc_r && !gga_r && !vtg_r))
    else $error("collection did not restart");

endmodule

`default_nettype wire

### hdl/nbc_out_stage.sv
// Result register stage: holds one result until the downstream side takes it.
`default_nettype none

module nbc_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire nbc_pkg::result_t  res,
  output logic                   free,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output nbc_pkg::result_t       out_res
);

  logic             valid_r;
  nbc_pkg::result_t res_r;

  // The register takes a new result when empty or emptied this cycle.
  assign free       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_res    = res_r;

  // Valid flag of the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire
